### hdl/mipd_pkg.sv
// Shared types, codes and table builders for the mip downsampler.
package mipd_pkg;

   localparam int TAB_BITS = 24;

   typedef logic [TAB_BITS-1:0] tab_type [256];

   typedef enum logic [1:0] {
      OP_STORE  = 2'd0,
      OP_LINE   = 2'd1,
      OP_DOUBLE = 2'd2
   } op_type;

   typedef struct packed {
      op_type op;
      logic   mode;
      logic   last;
   } ctl_type;

   localparam logic [1:0] REG_WIDTH  = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;
   localparam logic [1:0] REG_MODE   = 2'd2;

   localparam logic [63:0] Q30_ONE = 64'd1 << 30;

   // sRGB decode of code fraction n/510 to linear light, Q30
   function automatic logic [63:0] decode_q30(input int unsigned n);
      logic [63:0] y;
      logic [63:0] r;
      logic [63:0] cand;
      logic [63:0] p;
      logic [63:0] y2;
      logic [63:0] r2;
      if (n <= 20) begin
         return ((64'(n) << 30) * 64'd100 + 64'd329460) / 64'd658920;
      end
      y = ((64'(1000 * n + 28050) << 30) + 64'd269025) / 64'd538050;
      r = '0;
      for (int b = 30; b >= 0; b--) begin
         cand = r | (64'd1 << b);
         p = cand;
         for (int i = 0; i < 4; i++) begin
            p = (p * cand) >> 30;
         end
         if (cand <= Q30_ONE && p <= y) begin
            r = cand;
         end
      end
      y2 = (y * y) >> 30;
      r2 = (r * r) >> 30;
      return (y2 * r2) >> 30;
   endfunction

   function automatic logic [63:0] scale_lin(input logic [63:0] v, input int lb);
      logic [63:0] full;
      full = (64'd1 << lb) - 64'd1;
      return (v * full + (64'd1 << 29)) >> 30;
   endfunction

   function automatic tab_type lin_tab(input int lb);
      tab_type t;
      for (int i = 0; i < 256; i++) begin
         t[i] = TAB_BITS'(scale_lin(decode_q30(2 * i), lb));
      end
      return t;
   endfunction

   // code midpoint thresholds; the top entry is never addressed
   function automatic tab_type thr_tab(input int lb);
      tab_type t;
      for (int i = 0; i < 255; i++) begin
         t[i] = TAB_BITS'(scale_lin(decode_q30(2 * i + 1), lb));
      end
      t[255] = '1;
      return t;
   endfunction

endpackage

### hdl/mipd_if.sv
// Request and response channel interfaces.
interface mipd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_in;
   logic [7:0] green_in;
   logic [7:0] blue_in;
   logic [7:0] alpha_in;
   modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
   modport sink (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface mipd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_out;
   logic [7:0] green_out;
   logic [7:0] blue_out;
   logic [7:0] alpha_out;
   logic       level_done;
   modport source (output valid, red_out, green_out, blue_out, alpha_out, level_done,
                   input ready);
   modport sink (input valid, red_out, green_out, blue_out, alpha_out, level_done,
                 output ready);
endinterface

### hdl/mipd_front.sv
// Front end: config registers, position tracking, linearize and pair sums.
module mipd_front #(
   parameter int MAX_WIDTH   = 4096,
   parameter int LINEAR_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   mipd_req_if.sink                             req_chan,
   input  logic                                 csr_we,
   input  logic [1:0]                           csr_index,
   input  logic [15:0]                          csr_data,
   input  logic                                 q_full,
   output logic                                 push,
   output mipd_pkg::ctl_type                    push_ctl,
   output logic [((MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) - 1 : 1)-1:0] push_bx,
   output logic [4*(LINEAR_BITS+1)-1:0]         push_pair
);
   import mipd_pkg::*;

   localparam int XW = $clog2(MAX_WIDTH) + 1;
   localparam int AW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) - 1 : 1;
   localparam int CW = LINEAR_BITS;
   localparam int PW = LINEAR_BITS + 1;
   localparam tab_type LIN = lin_tab(LINEAR_BITS);

   logic [12:0]   width_ff;
   logic [15:0]   height_ff;
   logic          mode_ff;
   logic [XW-1:0] x_ff, x_in;
   logic [15:0]   y_ff, y_in;
   logic [CW-1:0] hold_ff [4];

   logic [XW-1:0] w, hw, owm1, bxf;
   logic [15:0]   h, hh, ohm1, by;
   logic          wone, hone, accept, have_pair, more_x, more_y, size_wr;
   logic [7:0]    code [4];
   logic [CW-1:0] px [4];

   assign req_chan.ready = !q_full;
   assign accept = req_chan.valid && !q_full;
   assign code[0] = req_chan.red_in;
   assign code[1] = req_chan.green_in;
   assign code[2] = req_chan.blue_in;
   assign code[3] = req_chan.alpha_in;

   always_comb begin
      if (width_ff == '0) begin
         w = XW'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w = XW'(MAX_WIDTH);
      end else begin
         w = XW'(width_ff);
      end
      h = (height_ff == '0) ? 16'd1 : height_ff;
      wone = (w == XW'(1));
      hone = (h == 16'd1);
      hw = w >> 1;
      hh = h >> 1;
      owm1 = (hw == '0) ? '0 : hw - XW'(1);
      ohm1 = (hh == '0) ? '0 : hh - 16'd1;
      bxf = x_ff >> 1;
      by = hone ? '0 : (y_ff >> 1);
      more_x = ({1'b0, x_ff} + (XW+1)'(1)) < {1'b0, w};
      more_y = ({1'b0, y_ff} + 17'd1) < {1'b0, h};
      have_pair = wone || x_ff[0];
      for (int c = 0; c < 4; c++) begin
         px[c] = (c < 3 && mode_ff) ? LIN[code[c]][CW-1:0] : CW'(code[c]);
         push_pair[c*PW +: PW] = wone ? ({1'b0, px[c]} << 1)
                                      : ({1'b0, hold_ff[c]} + {1'b0, px[c]});
      end
      if (hone) begin
         push_ctl.op = OP_DOUBLE;
      end else if (y_ff[0]) begin
         push_ctl.op = OP_LINE;
      end else begin
         push_ctl.op = OP_STORE;
      end
      push_ctl.mode = mode_ff;
      push_ctl.last = (bxf == owm1) && (by == ohm1);
      push = accept && have_pair && (hone || y_ff[0] || more_y);
      push_bx = x_ff[AW:1];
      if (more_x) begin
         x_in = x_ff + XW'(1);
         y_in = y_ff;
      end else begin
         x_in = '0;
         y_in = more_y ? y_ff + 16'd1 : '0;
      end
      size_wr = csr_we && (csr_index == REG_WIDTH || csr_index == REG_HEIGHT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 13'd2;
         height_ff <= 16'd2;
         mode_ff   <= 1'b1;
         x_ff      <= '0;
         y_ff      <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               REG_WIDTH:  width_ff  <= csr_data[12:0];
               REG_HEIGHT: height_ff <= csr_data;
               REG_MODE:   mode_ff   <= csr_data[0];
               default: ;
            endcase
         end
         if (size_wr) begin
            x_ff <= '0;
            y_ff <= '0;
         end else if (accept) begin
            x_ff <= x_in;
            y_ff <= y_in;
         end
      end
   end

   // even column pixel waits for its partner
   always_ff @(posedge clock) begin
      if (accept && !x_ff[0]) begin
         hold_ff <= px;
      end
   end

endmodule

### hdl/mipd_queue.sv
// Small register queue between front and back end.
module mipd_queue #(
   parameter int DW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  logic [DW-1:0] push_data,
   output logic          full,
   input  logic          pop,
   output logic          head_valid,
   output logic [DW-1:0] head_data
);
   localparam int DEPTH = 4;

   logic [DW-1:0] slot_ff [DEPTH];
   logic [1:0]    wr_ff, rd_ff;
   logic [2:0]    cnt_ff;
   logic          do_pop;

   assign full = (cnt_ff == 3'(DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_data = slot_ff[rd_ff];
   assign do_pop = pop && head_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 2'd1;
         if (do_pop) rd_ff <= rd_ff + 2'd1;
         if (push && !do_pop) begin
            cnt_ff <= cnt_ff + 3'd1;
         end else if (do_pop && !push) begin
            cnt_ff <= cnt_ff - 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_data;
   end

endmodule

### hdl/mipd_back.sv
// Back end: line buffer, box sum, mean and sRGB re-encode search pipeline.
module mipd_back #(
   parameter int MAX_WIDTH   = 4096,
   parameter int LINEAR_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 head_valid,
   input  mipd_pkg::ctl_type                    head_ctl,
   input  logic [((MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) - 1 : 1)-1:0] head_bx,
   input  logic [4*(LINEAR_BITS+1)-1:0]         head_pair,
   output logic                                 pop,
   mipd_rsp_if.source                           rsp_chan
);
   import mipd_pkg::*;

   localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
   localparam int CW = LINEAR_BITS;
   localparam int PW = LINEAR_BITS + 1;
   localparam int BW = LINEAR_BITS + 2;
   localparam int NS = 8;
   localparam tab_type TH = thr_tab(LINEAR_BITS);

   logic [4*PW-1:0] line_mem [LINE_DEPTH];
   logic [4*PW-1:0] rd_ff;

   logic            adv;
   logic            s1_v_ff;
   ctl_type         s1_ctl_ff;
   logic [4*PW-1:0] s1_pair_ff;

   logic            st_v_ff    [NS+1];
   logic            st_mode_ff [NS+1];
   logic            st_last_ff [NS+1];
   logic [CW-1:0]   st_m_ff    [NS+1][4];
   logic [7:0]      st_c_ff    [NS+1][3];
   logic [7:0]      st_c_in    [NS][3];
   logic [CW-1:0]   mean       [4];
   logic [BW-1:0]   box;
   logic [7:0]      cand;

   assign adv = !st_v_ff[NS] || rsp_chan.ready;
   assign pop = adv && head_valid;

   always_ff @(posedge clock) begin
      if (pop) begin
         if (head_ctl.op == OP_STORE) begin
            line_mem[head_bx] <= head_pair;
         end
         rd_ff <= line_mem[head_bx];
      end
   end

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         box = (s1_ctl_ff.op == OP_LINE)
               ? BW'(rd_ff[c*PW +: PW]) + BW'(s1_pair_ff[c*PW +: PW])
               : BW'(s1_pair_ff[c*PW +: PW]) << 1;
         box = box + BW'(2);
         mean[c] = box[BW-1:2];
      end
      // binary search over the sorted midpoint thresholds, one bit per stage
      for (int k = 0; k < NS; k++) begin
         for (int c = 0; c < 3; c++) begin
            cand = st_c_ff[k][c] | (8'd1 << (NS - 1 - k));
            st_c_in[k][c] = (st_m_ff[k][c] >= TH[cand - 8'd1][CW-1:0])
                            ? cand : st_c_ff[k][c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         for (int k = 0; k <= NS; k++) st_v_ff[k] <= 1'b0;
      end else if (adv) begin
         s1_v_ff <= head_valid && (head_ctl.op != OP_STORE);
         st_v_ff[0] <= s1_v_ff;
         for (int k = 0; k < NS; k++) st_v_ff[k+1] <= st_v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ctl_ff  <= head_ctl;
         s1_pair_ff <= head_pair;
         st_m_ff[0]    <= mean;
         st_mode_ff[0] <= s1_ctl_ff.mode;
         st_last_ff[0] <= s1_ctl_ff.last;
         for (int c = 0; c < 3; c++) st_c_ff[0][c] <= '0;
         for (int k = 0; k < NS; k++) begin
            st_m_ff[k+1]    <= st_m_ff[k];
            st_mode_ff[k+1] <= st_mode_ff[k];
            st_last_ff[k+1] <= st_last_ff[k];
            st_c_ff[k+1]    <= st_c_in[k];
         end
      end
   end

   assign rsp_chan.valid      = st_v_ff[NS];
   assign rsp_chan.red_out    = st_mode_ff[NS] ? st_c_ff[NS][0] : st_m_ff[NS][0][7:0];
   assign rsp_chan.green_out  = st_mode_ff[NS] ? st_c_ff[NS][1] : st_m_ff[NS][1][7:0];
   assign rsp_chan.blue_out   = st_mode_ff[NS] ? st_c_ff[NS][2] : st_m_ff[NS][2][7:0];
   assign rsp_chan.alpha_out  = st_m_ff[NS][3][7:0];
   assign rsp_chan.level_done = st_last_ff[NS];

endmodule

### hdl/srgb_box_mip_downsample.sv
// Top level of the sRGB-correct 2x2 box mip downsampler.
// Takes one RGBA8 source pixel per request in raster order and returns one
// pixel per 2x2 box; level_done marks the last pixel of a level. Sustained
// rate is one request per clock while responses are taken. The request that
// completes a box is registered in the queue, then passes the line buffer
// read, the box sum and mean, then eight search stages for the sRGB
// re-encode, the last of which drives the response.
// A stalled response freezes the whole back end; once the four-entry queue
// fills, request ready drops. Width and height writes restart the
// level; a mode write does not restart it. The line buffer holds one
// pair sum per output column and needs no clearing after reset.
module srgb_box_mip_downsample #(
   parameter int MAX_WIDTH   = 4096,
   parameter int LINEAR_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   mipd_req_if.sink    req_chan,
   mipd_rsp_if.source  rsp_chan,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import mipd_pkg::*;

   localparam int AW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) - 1 : 1;
   localparam int PW = LINEAR_BITS + 1;
   localparam int DW = $bits(ctl_type) + AW + 4 * PW;

   logic              push, q_full, head_valid, pop;
   ctl_type           push_ctl, head_ctl;
   logic [AW-1:0]     push_bx, head_bx;
   logic [4*PW-1:0]   push_pair, head_pair;
   logic [DW-1:0]     head_data;

   // front: classify each request and form horizontal pair sums
   mipd_front #(.MAX_WIDTH(MAX_WIDTH), .LINEAR_BITS(LINEAR_BITS)) u_front (
      .clock, .reset, .req_chan, .csr_we, .csr_index, .csr_data,
      .q_full, .push, .push_ctl, .push_bx, .push_pair
   );

   // decouples request intake from response back-pressure
   mipd_queue #(.DW(DW)) u_queue (
      .clock, .reset, .push,
      .push_data({push_ctl, push_bx, push_pair}),
      .full(q_full), .pop, .head_valid, .head_data
   );

   assign {head_ctl, head_bx, head_pair} = head_data;

   // back: vertical combine, mean and re-encode
   mipd_back #(.MAX_WIDTH(MAX_WIDTH), .LINEAR_BITS(LINEAR_BITS)) u_back (
      .clock, .reset, .head_valid, .head_ctl, .head_bx, .head_pair, .pop, .rsp_chan
   );

endmodule

### hdl/mipd_checker.sv
// Port-level checks for the downsampler, bound to the top level.
module mipd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_red,
   input logic [7:0] rsp_alpha,
   input logic       rsp_done
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_red)
                                  && $stable(rsp_alpha) && $stable(rsp_done))
      else $error("stalled response changed");

   a_latency: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid ##1 !rsp_valid ##1 !rsp_valid)
      else $error("response earlier than pipeline allows");

endmodule

bind srgb_box_mip_downsample mipd_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_red   (rsp_chan.red_out),
   .rsp_alpha (rsp_chan.alpha_out),
   .rsp_done  (rsp_chan.level_done)
);
